// ===== rtl/core/nsa_pkg.sv =====
// Shared types and constants for the notch slot allocator.
`timescale 1ns / 1ps
package nsa_pkg;

	// Field widths
	localparam int FREQ_W     = 19;
	localparam int LVL_W      = 10;
	localparam int AGE_W      = 16;
	localparam int SLOT_W     = 4;
	localparam int REQ_W      = 2;
	localparam int ACT_W      = 5;
	localparam int HOLD_W     = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = 36;
	localparam int STEP_W     = LVL_W + 1;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_TRIGGER = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACTIVE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_RELEASE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES  = 4'd3;

	// Depth constants in 1/20 dB
	localparam logic [LVL_W-1:0] DEEPEN_STEP = 10'd80;
	localparam logic [LVL_W-1:0] NEW_TARGET  = 10'd240;
	localparam logic [LVL_W-1:0] FADE_STEP   = 10'd12;
	localparam logic [LVL_W-1:0] FREE_BELOW  = 10'd20;
	localparam logic signed [STEP_W-1:0] STEP_DOWN = -11'sd16;
	localparam logic signed [STEP_W-1:0] STEP_UP   = 11'sd120;
	localparam logic signed [STEP_W-1:0] MOVE_MIN  = 11'sd1;
	localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;

	// Window of +-1/12 octave around the centre, scaled by 65536
	localparam logic [16:0] MATCH_LO = 17'd61858;
	localparam logic [16:0] MATCH_HI = 17'd69433;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_DEEPEN  = 3'd0,
		KIND_NEW     = 3'd1,
		KIND_RECYCLE = 3'd2,
		KIND_TICK    = 3'd3,
		KIND_CLEAR   = 3'd4
	} kind_t;

	// One notch slot
	typedef struct packed {
		logic              on;
		logic [FREQ_W-1:0] centre;
		logic [LVL_W-1:0]  target;
		logic [LVL_W-1:0]  level;
		logic [AGE_W-1:0]  age;
	} slot_rec_t;

	// Settings seen by the depth ramp
	typedef struct packed {
		logic [LVL_W-1:0]  max_depth;
		logic              auto_release;
		logic [HOLD_W-1:0] hold_frames;
	} ramp_cfg_t;

endpackage

// ===== rtl/core/notch_slot_allocator_and_depth_ramp.sv =====
// Top level: slot ring, request sequencer, result register and config registers.
`timescale 1ns / 1ps
// The slots live in a ring of NOTCH_SLOTS cells that rotates one place per
// cycle during a search, update or tick pass, so every slot passes the single
// head position, where the match multipliers and the depth ramp sit; each pass
// is NOTCH_SLOTS shifts and leaves the ring in its home position. A trigger
// takes a search pass on registered products, a decision state, an update
// pass and an emit state that loads the result; it gives no result when no
// slot can be taken. A tick emits one report per cycle while the output is not
// stalled, one slot per shift, NOTCH_SLOTS reports in all; the ring waits while
// the output stalls. A clear frees all slots at once and delivers its result
// through the emit state. A new request is accepted once the last result of
// the previous one is in the output register, or once a trigger with no result
// has decided. Configuration writes are always taken (cfg_ready is tied high);
// writes to unused indexes are ignored.
module notch_slot_allocator_and_depth_ramp #(
	parameter int NOTCH_SLOTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [nsa_pkg::REQ_W-1:0]         req_type,
	input  logic [nsa_pkg::FREQ_W-1:0]        freq,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        kind,
	output logic [nsa_pkg::SLOT_W-1:0]        slot,
	output logic                              active,
	output logic [nsa_pkg::FREQ_W-1:0]        notch_freq,
	output logic [nsa_pkg::LVL_W-1:0]         depth,
	output logic                              changed,
	output logic                              last,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nsa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nsa_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = (NOTCH_SLOTS > 1) ? $clog2(NOTCH_SLOTS) : 1;
	localparam int CNT_W = $clog2(NOTCH_SLOTS + 1);
	localparam int CMP_W = (CNT_W > nsa_pkg::ACT_W) ? CNT_W : nsa_pkg::ACT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTCH_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_APPLY,
		S_EMIT,
		S_TICK
	} state_t;

	state_t state_q;

	// configuration
	logic [nsa_pkg::ACT_W-1:0]  max_active_q;
	logic [nsa_pkg::LVL_W-1:0]  max_depth_q;
	logic                       auto_release_q;
	logic [nsa_pkg::HOLD_W-1:0] hold_frames_q;
	nsa_pkg::ramp_cfg_t         ramp_cfg;

	// ring
	nsa_pkg::slot_rec_t rec [NOTCH_SLOTS];
	nsa_pkg::slot_rec_t head;
	nsa_pkg::slot_rec_t tail_rec;
	nsa_pkg::slot_rec_t mod_rec;
	nsa_pkg::slot_rec_t ramp_rec;
	logic               ramp_chg;
	logic               ring_shift;
	logic               ring_clr;

	// sequencing
	logic [IDX_W-1:0]          k_q;
	logic                      swept_q;
	logic [nsa_pkg::FREQ_W-1:0] freq_q;
	logic                      accept;
	logic                      out_free;
	logic                      load_out;
	logic                      at_pick;

	// search stage
	logic                      valid_s1;
	logic                      on_s1;
	logic [nsa_pkg::AGE_W-1:0] age_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic [nsa_pkg::PROD_W-1:0] lo_s1;
	logic [nsa_pkg::PROD_W-1:0] hi_s1;
	logic [nsa_pkg::PROD_W-1:0] fs;
	logic                      match;

	// search results
	logic                      found_q;
	logic [IDX_W-1:0]          match_idx_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      free_found_q;
	logic [IDX_W-1:0]          free_idx_q;
	logic                      any_on_q;
	logic [nsa_pkg::AGE_W-1:0] best_age_q;
	logic [IDX_W-1:0]          old_idx_q;
	logic [IDX_W-1:0]          pick_q;

	// pending single result
	nsa_pkg::kind_t             res_kind_q;
	logic [nsa_pkg::SLOT_W-1:0] res_slot_q;
	logic                       res_active_q;
	logic [nsa_pkg::FREQ_W-1:0] res_freq_q;
	logic [nsa_pkg::LVL_W-1:0]  res_depth_q;

	// output register
	logic                       out_valid_q;
	nsa_pkg::kind_t             out_kind_q;
	logic [nsa_pkg::SLOT_W-1:0] out_slot_q;
	logic                       out_active_q;
	logic [nsa_pkg::FREQ_W-1:0] out_freq_q;
	logic [nsa_pkg::LVL_W-1:0]  out_depth_q;
	logic                       out_changed_q;
	logic                       out_last_q;

	// deepen and new-slot targets
	logic [nsa_pkg::STEP_W-1:0] deep_sum;
	logic [nsa_pkg::LVL_W-1:0]  deep_tgt;
	logic [nsa_pkg::LVL_W-1:0]  new_tgt;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_active_q   <= 5'd8;
			max_depth_q    <= 10'd360;
			auto_release_q <= 1'b0;
			hold_frames_q  <= 16'd750;
		end else if (cfg_valid) begin
			case (cfg_index)
				nsa_pkg::REG_MAX_ACTIVE:   max_active_q   <= cfg_data[nsa_pkg::ACT_W-1:0];
				nsa_pkg::REG_MAX_DEPTH:    max_depth_q    <= cfg_data[nsa_pkg::LVL_W-1:0];
				nsa_pkg::REG_AUTO_RELEASE: auto_release_q <= cfg_data[0];
				nsa_pkg::REG_HOLD_FRAMES:  hold_frames_q  <= cfg_data[nsa_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign ramp_cfg = {max_depth_q, auto_release_q, hold_frames_q};

	// Handshake and ring control
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = ((state_q == S_EMIT) || (state_q == S_TICK)) && out_free;
	assign ring_clr = accept && (req_type == nsa_pkg::REQ_CLEAR);
	assign ring_shift = ((state_q == S_SCAN) && !swept_q) || (state_q == S_APPLY) ||
		((state_q == S_TICK) && out_free);
	assign at_pick = (k_q == pick_q);
	assign head    = rec[0];

	// Slot ring
	for (genvar i = 0; i < NOTCH_SLOTS; i++) begin : g_ring
		if (i == NOTCH_SLOTS - 1) begin : g_tail
			nsa_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ring_shift),
				.clr    (ring_clr),
				.d      (tail_rec),
				.q      (rec[i])
			);
		end else begin : g_mid
			nsa_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ring_shift),
				.clr    (ring_clr),
				.d      (rec[i+1]),
				.q      (rec[i])
			);
		end
	end

	// Tick update of the head slot
	nsa_ramp u_ramp (
		.cfg     (ramp_cfg),
		.cur     (head),
		.nxt     (ramp_rec),
		.changed (ramp_chg)
	);

	// Trigger update of the picked slot
	always_comb begin
		deep_sum = {1'b0, head.target} + {1'b0, nsa_pkg::DEEPEN_STEP};
		deep_tgt = (deep_sum > {1'b0, max_depth_q}) ? max_depth_q :
			deep_sum[nsa_pkg::LVL_W-1:0];
		new_tgt  = (nsa_pkg::NEW_TARGET < max_depth_q) ? nsa_pkg::NEW_TARGET : max_depth_q;
		mod_rec  = head;
		if (res_kind_q == nsa_pkg::KIND_DEEPEN) begin
			mod_rec.target = deep_tgt;
			mod_rec.age    = '0;
		end else begin
			mod_rec.on     = 1'b1;
			mod_rec.centre = freq_q;
			mod_rec.target = new_tgt;
			mod_rec.level  = '0;
			mod_rec.age    = '0;
		end
	end

	// Record fed back into the ring tail
	always_comb begin
		case (state_q)
			S_APPLY: tail_rec = at_pick ? mod_rec : head;
			S_TICK:  tail_rec = ramp_rec;
			default: tail_rec = head;
		endcase
	end

	// Window compare on registered products
	assign fs    = nsa_pkg::PROD_W'({freq_q, 16'd0});
	assign match = on_s1 && (lo_s1 <= fs) && (fs < hi_s1);

	// Search stage: products of the head slot's centre
	always_ff @(posedge clk) begin
		on_s1  <= head.on;
		age_s1 <= head.age;
		idx_s1 <= k_q;
		lo_s1  <= nsa_pkg::PROD_W'(head.centre * nsa_pkg::MATCH_LO);
		hi_s1  <= nsa_pkg::PROD_W'(head.centre * nsa_pkg::MATCH_HI);
	end

	// Sequencer, search bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			k_q           <= '0;
			swept_q       <= 1'b0;
			valid_s1      <= 1'b0;
			freq_q        <= '0;
			found_q       <= 1'b0;
			match_idx_q   <= '0;
			cnt_q         <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			any_on_q      <= 1'b0;
			best_age_q    <= '0;
			old_idx_q     <= '0;
			pick_q        <= '0;
			res_kind_q    <= nsa_pkg::KIND_CLEAR;
			res_slot_q    <= '0;
			res_active_q  <= 1'b0;
			res_freq_q    <= '0;
			res_depth_q   <= '0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= nsa_pkg::KIND_CLEAR;
			out_slot_q    <= '0;
			out_active_q  <= 1'b0;
			out_freq_q    <= '0;
			out_depth_q   <= '0;
			out_changed_q <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			// a new result loads, a stalled one holds, an accepted one leaves
			out_valid_q <= load_out || (out_valid_q && out_stall);
			valid_s1    <= (state_q == S_SCAN) && !swept_q;

			case (state_q)
				S_IDLE: begin
					k_q     <= '0;
					swept_q <= 1'b0;
					if (accept) begin
						freq_q       <= freq;
						found_q      <= 1'b0;
						cnt_q        <= '0;
						free_found_q <= 1'b0;
						any_on_q     <= 1'b0;
						case (req_type)
							nsa_pkg::REQ_TRIGGER: state_q <= S_SCAN;
							nsa_pkg::REQ_TICK:    state_q <= S_TICK;
							nsa_pkg::REQ_CLEAR: begin
								res_kind_q   <= nsa_pkg::KIND_CLEAR;
								res_slot_q   <= '0;
								res_active_q <= 1'b0;
								res_freq_q   <= '0;
								res_depth_q  <= '0;
								state_q      <= S_EMIT;
							end
							default: ;
						endcase
					end
				end

				S_SCAN: begin
					if (!swept_q) begin
						if (k_q == LAST_IDX) begin
							swept_q <= 1'b1;
							k_q     <= '0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
					if (valid_s1) begin
						if (on_s1) begin
							if (!found_q && match) begin
								found_q     <= 1'b1;
								match_idx_q <= idx_s1;
							end
							cnt_q <= cnt_q + 1'b1;
							// oldest active slot, first one on a tie
							if (!any_on_q || (age_s1 > best_age_q)) begin
								any_on_q   <= 1'b1;
								best_age_q <= age_s1;
								old_idx_q  <= idx_s1;
							end
						end else if (!free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_s1;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= S_DECIDE;
						end
					end
				end

				S_DECIDE: begin
					k_q          <= '0;
					res_active_q <= 1'b1;
					if (found_q) begin
						res_kind_q <= nsa_pkg::KIND_DEEPEN;
						pick_q     <= match_idx_q;
						res_slot_q <= nsa_pkg::SLOT_W'(match_idx_q);
						state_q    <= S_APPLY;
					end else if ((CMP_W'(cnt_q) < CMP_W'(max_active_q)) && free_found_q) begin
						res_kind_q <= nsa_pkg::KIND_NEW;
						pick_q     <= free_idx_q;
						res_slot_q <= nsa_pkg::SLOT_W'(free_idx_q);
						state_q    <= S_APPLY;
					end else if (any_on_q) begin
						res_kind_q <= nsa_pkg::KIND_RECYCLE;
						pick_q     <= old_idx_q;
						res_slot_q <= nsa_pkg::SLOT_W'(old_idx_q);
						state_q    <= S_APPLY;
					end else begin
						// no slot to take: no result
						state_q <= S_IDLE;
					end
				end

				S_APPLY: begin
					if (at_pick) begin
						res_freq_q  <= mod_rec.centre;
						res_depth_q <= mod_rec.level;
					end
					if (k_q == LAST_IDX) begin
						k_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end

				S_EMIT: begin
					if (out_free) begin
						out_kind_q    <= res_kind_q;
						out_slot_q    <= res_slot_q;
						out_active_q  <= res_active_q;
						out_freq_q    <= res_active_q ? res_freq_q : '0;
						out_depth_q   <= res_depth_q;
						out_changed_q <= 1'b0;
						out_last_q    <= 1'b1;
						state_q       <= S_IDLE;
					end
				end

				S_TICK: begin
					if (out_free) begin
						out_kind_q    <= nsa_pkg::KIND_TICK;
						out_slot_q    <= nsa_pkg::SLOT_W'(k_q);
						out_active_q  <= ramp_rec.on;
						out_freq_q    <= ramp_rec.on ? ramp_rec.centre : '0;
						out_depth_q   <= ramp_rec.level;
						out_changed_q <= ramp_chg;
						out_last_q    <= (k_q == LAST_IDX);
						if (k_q == LAST_IDX) begin
							k_q     <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = out_kind_q;
	assign slot       = out_slot_q;
	assign active     = out_active_q;
	assign notch_freq = out_freq_q;
	assign depth      = out_depth_q;
	assign changed    = out_changed_q;
	assign last       = out_last_q;

endmodule

// ===== rtl/core/nsa_cell.sv =====
// One slot cell of the rotating slot ring.
`timescale 1ns / 1ps
module nsa_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  logic                clr,
	input  nsa_pkg::slot_rec_t  d,
	output nsa_pkg::slot_rec_t  q
);

	nsa_pkg::slot_rec_t rec_q;

	// Hold the slot, clear it on clr, take the neighbor's record on shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (clr) begin
			rec_q <= '0;
		end else if (shift) begin
			rec_q <= d;
		end
	end

	assign q = rec_q;

endmodule

// ===== rtl/core/nsa_ramp.sv =====
// Per-frame aging, fade-out and depth ramp of the slot at the ring head.
`timescale 1ns / 1ps
module nsa_ramp (
	input  nsa_pkg::ramp_cfg_t  cfg,
	input  nsa_pkg::slot_rec_t  cur,
	output nsa_pkg::slot_rec_t  nxt,
	output logic                changed
);

	logic [nsa_pkg::AGE_W-1:0]         age_inc;
	logic [nsa_pkg::LVL_W-1:0]         tgt_c;
	logic [nsa_pkg::LVL_W-1:0]         tgt;
	logic                              fade;
	logic                              free;
	logic signed [nsa_pkg::STEP_W-1:0] step_raw;
	logic signed [nsa_pkg::STEP_W-1:0] step;
	logic                              move;
	logic [nsa_pkg::STEP_W-1:0]        lvl_sum;
	logic [nsa_pkg::LVL_W-1:0]         lvl_new;

	// Saturating age, target clamp, fade decision
	always_comb begin
		age_inc = (cur.age != nsa_pkg::AGE_MAX) ? cur.age + 16'd1 : cur.age;
		tgt_c   = (cur.target > cfg.max_depth) ? cfg.max_depth : cur.target;
		fade    = cfg.auto_release && (age_inc > cfg.hold_frames);
		// faded target below the free level
		free    = fade && (tgt_c < (nsa_pkg::FADE_STEP + nsa_pkg::FREE_BELOW));
		tgt     = fade ? tgt_c - nsa_pkg::FADE_STEP : tgt_c;
	end

	// Clamped step toward the target
	always_comb begin
		step_raw = $signed({1'b0, tgt}) - $signed({1'b0, cur.level});
		if (step_raw < nsa_pkg::STEP_DOWN) begin
			step = nsa_pkg::STEP_DOWN;
		end else if (step_raw > nsa_pkg::STEP_UP) begin
			step = nsa_pkg::STEP_UP;
		end else begin
			step = step_raw;
		end
		move    = (step > nsa_pkg::MOVE_MIN) || (step < -nsa_pkg::MOVE_MIN);
		lvl_sum = {1'b0, cur.level} + step;
		lvl_new = move ? lvl_sum[nsa_pkg::LVL_W-1:0] : cur.level;
	end

	// Next record
	always_comb begin
		nxt = cur;
		if (cur.on) begin
			nxt.age = age_inc;
			if (free) begin
				nxt.on     = 1'b0;
				nxt.target = '0;
				nxt.level  = '0;
			end else begin
				nxt.target = tgt;
				nxt.level  = lvl_new;
			end
		end
	end

	assign changed = (nxt.level != cur.level);

endmodule

// ===== rtl/core/nsa_checker.sv =====
// Port-level checks on the notch slot allocator, bound to the top level.
`timescale 1ns / 1ps
module nsa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    kind,
	input logic [nsa_pkg::SLOT_W-1:0]    slot,
	input logic                          active,
	input logic [nsa_pkg::FREQ_W-1:0]    notch_freq,
	input logic [nsa_pkg::LVL_W-1:0]     depth,
	input logic                          last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot) && $stable(depth))
		else $error("stalled result changed");

	// no new request while a tick report sequence is still in flight
	a_busy_mid_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("request accepted in the middle of a tick transaction");

	// inactive slots report no frequency
	a_idle_freq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> notch_freq == '0)
		else $error("inactive slot shows a frequency");

	// trigger and clear transactions give a single result
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == nsa_pkg::KIND_DEEPEN || kind == nsa_pkg::KIND_NEW ||
		kind == nsa_pkg::KIND_RECYCLE || kind == nsa_pkg::KIND_CLEAR) |-> last)
		else $error("single result not marked last");

endmodule

bind notch_slot_allocator_and_depth_ramp nsa_checker u_nsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.kind       (kind),
	.slot       (slot),
	.active     (active),
	.notch_freq (notch_freq),
	.depth      (depth),
	.last       (last)
);
